>>> rtl/m3inv_pkg.sv
// Package: element width, payload structs for the 3x3 adjugate inverse.
`timescale 1ns / 1ps
package m3inv_pkg;

  localparam int ELEM_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t a00;
    elem_t a01;
    elem_t a02;
    elem_t a10;
    elem_t a11;
    elem_t a12;
    elem_t a20;
    elem_t a21;
    elem_t a22;
  } matrix_t;

  typedef struct packed {
    elem_t inv00;
    elem_t inv01;
    elem_t inv02;
    elem_t inv10;
    elem_t inv11;
    elem_t inv12;
    elem_t inv20;
    elem_t inv21;
    elem_t inv22;
    elem_t det_value;
    logic  singular;
  } result_t;

endpackage

>>> rtl/matrix3_inverse_adjugate.sv
// 3x3 fixed point matrix inverse by adjugate and determinant, fully pipelined.
//
// Usage: drive a matrix on matrix and raise start; the beat is taken at the
// rising edge where start is high and busy is low. busy is high only during
// reset, so one matrix can be taken every cycle.
// Each matrix yields one result beat on result, marked by done for exactly
// one cycle. Throughput is one matrix per cycle.
// Front end: 2x2 cofactor products, cofactors, determinant by expansion along
// row 0 with split partial products, magnitudes and rounding numerators
// (seven stages). Back end: one overflow check stage and ELEM_WIDTH restoring
// divider stages, one quotient bit each, nine lanes side by side, then the
// saturating output register. Latency is set by the front end and that divider chain.
// Singular input (exact determinant zero) gives zero elements, det_value 0
// and singular set. Overflowing values saturate.
// Reset (rst, synchronous) empties the pipeline; items in flight are dropped.
// The receiver cannot stall: a result beat is presented once and not held.
`timescale 1ns / 1ps
module matrix3_inverse_adjugate
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  matrix_t matrix,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int W    = ELEM_WIDTH;
  localparam int WP   = 2 * W;
  localparam int WC   = 2 * W + 1;
  localparam int WD   = 3 * W + 3;
  localparam int WNA  = WC + 2 * FRAC_BITS + 1;
  localparam int WN   = ((WNA > WD) ? WNA : WD) + 1;
  localparam int WR   = (WN > WD + W + 1) ? WN : WD + W + 1;
  localparam int LAT  = W + 9;
  localparam int SH   = 2 * FRAC_BITS;

  localparam logic [W-1:0]  MINP = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  MAXP = ~MINP;
  localparam logic [WD:0]   RND  = (WD+1)'(1) << (SH - 1);
  localparam logic [WD:0]   MINX = {{(WD+1-W){1'b0}}, MINP};
  localparam logic [WD:0]   MAXX = {{(WD+1-W){1'b0}}, MAXP};

  // cofactor k = a[P]*a[Q] - a[R]*a[S], elements numbered row*3+col
  localparam int CP [0:8] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int CQ [0:8] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int CR [0:8] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int CS [0:8] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  typedef struct packed {
    logic         zero;
    logic [8:0]   neg;
    logic [8:0]   ovf;
    logic [W-1:0] det;
  } dside_t;

  logic signed [W-1:0] a [0:8];

  assign busy = rst;

  assign a[0] = matrix.a00;
  assign a[1] = matrix.a01;
  assign a[2] = matrix.a02;
  assign a[3] = matrix.a10;
  assign a[4] = matrix.a11;
  assign a[5] = matrix.a12;
  assign a[6] = matrix.a20;
  assign a[7] = matrix.a21;
  assign a[8] = matrix.a22;

  logic                 v1, v2, v3, v4, v5, v6, v7;
  logic signed [WP-1:0] p1 [0:17];
  logic signed [W-1:0]  r1 [0:2];
  logic signed [W-1:0]  r2 [0:2];
  logic signed [WC-1:0] c2 [0:8];
  logic signed [WC-1:0] c3 [0:8];
  logic signed [WC-1:0] c4 [0:8];
  logic signed [WC-1:0] c5 [0:8];
  logic signed [WC:0]   ml3 [0:2];
  logic signed [WC:0]   mh3 [0:2];
  logic signed [WD-1:0] t4 [0:2];
  logic signed [WD-1:0] d5;
  logic [WD-1:0]        magd6;
  logic                 negd6;
  logic                 zero6;
  logic [WC-1:0]        cm6 [0:8];
  logic [8:0]           cn6;
  logic [WR-1:0]        num7 [0:8];
  logic [WR-1:0]        dvs7;
  logic [8:0]           neg7;
  logic                 zero7;
  logic [W-1:0]         det7;
  logic [WD:0]          detr;
  logic [W-1:0]         det_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // det rounding and saturation
  always_comb begin
    detr = ({1'b0, magd6} + RND) >> SH;
    if (negd6) begin
      det_next = (detr > MINX) ? MINP : W'(-detr[W-1:0]);
    end else begin
      det_next = (detr > MAXX) ? MAXP : detr[W-1:0];
    end
  end

  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_cof
      always_ff @(posedge clk) begin
        p1[2*k]   <= WP'(a[CP[k]]) * WP'(a[CQ[k]]);
        p1[2*k+1] <= WP'(a[CR[k]]) * WP'(a[CS[k]]);
        c2[k]     <= WC'(p1[2*k]) - WC'(p1[2*k+1]);
        c3[k]     <= c2[k];
        c4[k]     <= c3[k];
        c5[k]     <= c4[k];
        cm6[k]    <= c5[k][WC-1] ? WC'(-c5[k]) : WC'(c5[k]);
        cn6[k]    <= c5[k][WC-1];
      end
    end

    for (k = 0; k < 3; k++) begin : g_det
      always_ff @(posedge clk) begin
        r1[k]  <= a[k];
        r2[k]  <= r1[k];
        ml3[k] <= (WC+1)'(r2[k]) * (WC+1)'($signed({1'b0, c2[k][W-1:0]}));
        mh3[k] <= (WC+1)'(r2[k]) * (WC+1)'($signed(c2[k][WC-1:W]));
        t4[k]  <= (WD'(mh3[k]) <<< W) + WD'(ml3[k]);
      end
    end

    for (k = 0; k < 9; k++) begin : g_num
      localparam int SRC = (k % 3) * 3 + k / 3;
      always_ff @(posedge clk) begin
        num7[k] <= (WR'(cm6[SRC]) << (SH + 1)) + WR'(magd6);
        neg7[k] <= cn6[SRC] ^ negd6;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    d5    <= t4[0] + t4[1] + t4[2];
    magd6 <= d5[WD-1] ? WD'(-d5) : WD'(d5);
    negd6 <= d5[WD-1];
    zero6 <= (d5 == '0);
    dvs7  <= WR'(magd6) << 1;
    zero7 <= zero6;
    det7  <= det_next;
  end

  // divider chain: stage 0 checks overflow, stage s yields quotient bit W-s
  logic          dv   [0:W];
  dside_t        side [0:W];
  logic [WR-1:0] dvs  [0:W];
  logic [WR-1:0] rem  [0:W][0:8];
  logic [W-1:0]  quo  [0:W][0:8];
  logic [8:0]    ovf0;

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      ovf0[l] = (num7[l] >= (dvs7 << W));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v7;
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= '{zero: zero7, neg: neg7, ovf: ovf0, det: det7};
    dvs[0]  <= dvs7;
    for (int l = 0; l < 9; l++) begin
      rem[0][l] <= num7[l];
      quo[0][l] <= '0;
    end
  end

  genvar s;
  generate
    for (s = 1; s <= W; s++) begin : g_div
      logic [WR:0]   trial [0:8];
      logic [WR-1:0] dsh;

      always_comb begin
        dsh = dvs[s-1] << (W - s);
        for (int l = 0; l < 9; l++) begin
          trial[l] = {1'b0, rem[s-1][l]} - {1'b0, dsh};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          dv[s] <= 1'b0;
        end else begin
          dv[s] <= dv[s-1];
        end
      end

      always_ff @(posedge clk) begin
        side[s] <= side[s-1];
        dvs[s]  <= dvs[s-1];
        for (int l = 0; l < 9; l++) begin
          rem[s][l] <= trial[l][WR] ? rem[s-1][l] : trial[l][WR-1:0];
          quo[s][l] <= {quo[s-1][l][W-2:0], ~trial[l][WR]};
        end
      end
    end
  endgenerate

  logic [W-1:0] invn [0:8];
  result_t      result_next;

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      if (side[W].zero) begin
        invn[l] = '0;
      end else if (side[W].neg[l]) begin
        invn[l] = (side[W].ovf[l] || quo[W][l] > MINP) ? MINP : W'(-quo[W][l]);
      end else begin
        invn[l] = (side[W].ovf[l] || quo[W][l][W-1]) ? MAXP : quo[W][l];
      end
    end
    result_next.inv00     = invn[0];
    result_next.inv01     = invn[1];
    result_next.inv02     = invn[2];
    result_next.inv10     = invn[3];
    result_next.inv11     = invn[4];
    result_next.inv12     = invn[5];
    result_next.inv20     = invn[6];
    result_next.inv21     = invn[7];
    result_next.inv22     = invn[8];
    result_next.det_value = side[W].det;
    result_next.singular  = side[W].zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[W];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted matrix gave no result beat after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without a matching accepted matrix");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.singular |-> result.det_value == '0 && result.inv00 == '0 &&
      result.inv11 == '0 && result.inv22 == '0 && result.inv02 == '0)
    else $error("singular result with nonzero elements");

endmodule

>>> sim/m3inv_checker.sv
// Checker: predicts the inverse of each accepted matrix and compares result beats.
`timescale 1ns / 1ps
module m3inv_checker
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  matrix_t matrix,
  input  logic    done,
  input  result_t result,
  output int      errors,
  output int      pending
);

  typedef logic signed [191:0] wide_t;

  result_t inverse_q[$];

  function automatic elem_t saturate(wide_t mag, logic neg);
    wide_t lim;
    lim = wide_t'(1) <<< (ELEM_WIDTH - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      return elem_t'(-mag);
    end
    if (mag > lim - 1) mag = lim - 1;
    return elem_t'(mag);
  endfunction

  function automatic result_t invert(matrix_t m);
    wide_t a[3][3];
    wide_t c[3][3];
    wide_t det, magd, cc, num, q;
    elem_t e[9];
    logic negd, neg;
    result_t r;
    a[0][0] = wide_t'(m.a00); a[0][1] = wide_t'(m.a01); a[0][2] = wide_t'(m.a02);
    a[1][0] = wide_t'(m.a10); a[1][1] = wide_t'(m.a11); a[1][2] = wide_t'(m.a12);
    a[2][0] = wide_t'(m.a20); a[2][1] = wide_t'(m.a21); a[2][2] = wide_t'(m.a22);
    c[0][0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
    c[0][1] = a[1][2] * a[2][0] - a[1][0] * a[2][2];
    c[0][2] = a[1][0] * a[2][1] - a[1][1] * a[2][0];
    c[1][0] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
    c[1][1] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
    c[1][2] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
    c[2][0] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
    c[2][1] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
    c[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
    det = a[0][0] * a[1][1] * a[2][2] + a[0][1] * a[1][2] * a[2][0]
        + a[0][2] * a[1][0] * a[2][1] - a[0][2] * a[1][1] * a[2][0]
        - a[0][0] * a[1][2] * a[2][1] - a[0][1] * a[1][0] * a[2][2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    negd = det < 0;
    magd = negd ? -det : det;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cc  = c[j][i];
        neg = (cc < 0) != negd;
        if (cc < 0) cc = -cc;
        num = (cc <<< (2 * FRAC_BITS + 1)) + magd;
        q   = num / (magd <<< 1);
        e[i * 3 + j] = saturate(q, neg);
      end
    end
    r.inv00 = e[0]; r.inv01 = e[1]; r.inv02 = e[2];
    r.inv10 = e[3]; r.inv11 = e[4]; r.inv12 = e[5];
    r.inv20 = e[6]; r.inv21 = e[7]; r.inv22 = e[8];
    r.det_value = saturate((magd + (wide_t'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS),
                           negd);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ELEM_WIDTH-1:0] got,
                                 logic [ELEM_WIDTH-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  initial pending = 0;

  always @(posedge clk) begin
    result_t want;
    string names[10];
    names = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12", "inv20", "inv21",
              "inv22", "det_value"};
    if (!rst && start && !busy) inverse_q.push_back(invert(matrix));
    if (!rst && done) begin
      if (inverse_q.size() == 0) begin
        report_mismatch("unexpected beat", '0, '0);
      end else begin
        want = inverse_q.pop_front();
        for (int k = 0; k < 10; k++) begin
          if (result[1 + ELEM_WIDTH * (9 - k) +: ELEM_WIDTH]
              !== want[1 + ELEM_WIDTH * (9 - k) +: ELEM_WIDTH])
            report_mismatch(names[k], result[1 + ELEM_WIDTH * (9 - k) +: ELEM_WIDTH],
                            want[1 + ELEM_WIDTH * (9 - k) +: ELEM_WIDTH]);
        end
        if (result.singular !== want.singular)
          report_mismatch("singular", ELEM_WIDTH'(result.singular), ELEM_WIDTH'(want.singular));
      end
    end
    pending = inverse_q.size();
  end

endmodule

>>> sim/tb_matrix3_inverse_adjugate.sv
// Testbench top: drives matrices into the 3x3 inverse and gives the verdict.
`timescale 1ns / 1ps
module tb_matrix3_inverse_adjugate;
  import m3inv_pkg::*;

  localparam elem_t ONE  = elem_t'(1) <<< FRAC_BITS_DEF;
  localparam elem_t EMAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam elem_t EMIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  localparam int    N_RANDOM = 1300;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  matrix_t matrix = '0;
  logic    busy, done;
  result_t result;
  int      errors, pending;

  always #5 clk = ~clk;

  matrix3_inverse_adjugate u_dut (
    .clk(clk), .rst(rst), .start(start), .matrix(matrix),
    .busy(busy), .done(done), .result(result)
  );

  m3inv_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .matrix(matrix),
    .done(done), .result(result), .errors(errors), .pending(pending)
  );

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 2 * 8 * 65536)) - 8 * 65536);
      2: return elem_t'($signed($urandom_range(0, 512)) - 256);
      default: begin
        case ($urandom_range(0, 4))
          0: return EMAX;
          1: return EMIN;
          2: return '0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    elem_t e[9];
    int kind;
    matrix_t m;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++)
      e[k] = rand_elem(kind < 2 ? 0 : kind < 7 ? 1 : kind < 8 ? 2 : $urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) begin
      // duplicate a row: exactly singular
      for (int k = 0; k < 3; k++) e[6 + k] = e[k];
    end
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  task automatic send(matrix_t m, logic allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start  <= 1'b1;
    matrix <= m;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    matrix_t d[$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    d.push_back({ONE, elem_t'(0), elem_t'(0), elem_t'(0), ONE, elem_t'(0),
                 elem_t'(0), elem_t'(0), ONE});
    d.push_back('0);
    d.push_back({9{EMAX}});
    d.push_back({9{EMIN}});
    d.push_back({EMAX, elem_t'(0), elem_t'(0), elem_t'(0), EMAX, elem_t'(0),
                 elem_t'(0), elem_t'(0), EMAX});
    d.push_back({EMIN, elem_t'(0), elem_t'(0), elem_t'(0), EMIN, elem_t'(0),
                 elem_t'(0), elem_t'(0), EMIN});
    // tiny determinant: rounds to zero but not singular
    d.push_back({elem_t'(1), elem_t'(0), elem_t'(0), elem_t'(0), elem_t'(1), elem_t'(0),
                 elem_t'(0), elem_t'(0), elem_t'(1)});
    d.push_back({elem_t'(-1), elem_t'(0), elem_t'(0), elem_t'(0), ONE, elem_t'(0),
                 elem_t'(0), elem_t'(0), ONE});
    d.push_back({EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, elem_t'(0), elem_t'(1), elem_t'(-1)});
    d.push_back({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
    d.push_back({2 * ONE, elem_t'(0), elem_t'(0), elem_t'(0), -ONE / 2, elem_t'(0),
                 elem_t'(0), elem_t'(0), 4 * ONE});
    d.push_back({elem_t'(0), ONE, elem_t'(0), ONE, elem_t'(0), elem_t'(0),
                 elem_t'(0), elem_t'(0), -ONE});
    d.push_back({9{elem_t'(-1)}});
    d.push_back({EMAX, EMIN, elem_t'(0), elem_t'(0), EMAX, EMIN, EMIN, elem_t'(0), EMAX});
    foreach (d[i]) send(d[i], 1'b1);

    for (int n = 0; n < N_RANDOM; n++) send(rand_matrix(), n < N_RANDOM - 150);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule

>>> matrix3_inverse_adjugate.f
rtl/m3inv_pkg.sv
rtl/matrix3_inverse_adjugate.sv
sim/m3inv_checker.sv
sim/tb_matrix3_inverse_adjugate.sv
